// File: hdl/rpn_pkg.sv
`timescale 1ns / 1ps

package rpn_pkg;

    // Datapath and field widths
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 5;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;

    // Defaults
    localparam int DEF_STACK_DEPTH = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Register map: word index taken from paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_STACK_LIMIT = 1'b0;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // Token characters
    localparam logic [DATA_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [DATA_W-1:0] CH_NINE  = 8'd57;
    localparam logic [DATA_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [DATA_W-1:0] CH_MINUS = 8'd45;
    localparam logic [DATA_W-1:0] CH_STAR  = 8'd42;
    localparam logic [DATA_W-1:0] CH_SLASH = 8'd47;

    // Divider step counter width
    localparam int DIV_STEP_W = $clog2(DATA_W);

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_END,
        S_END_OUT,
        S_POP_A,
        S_POP_B,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_EMIT
    } t_state;

endpackage

// File: hdl/rpn_digit_stack_calculator.sv
`timescale 1ns / 1ps

// RPN digit stack calculator.
// Input channel (i_in_valid / o_in_ready) takes one ASCII character per
// transaction, or an end marker (i_is_end). Digits push 0..9, + - * / pop two
// values and push the 8-bit wrapped result. The end marker pops the top value
// and sends it on the output channel (o_out_valid / i_out_ready) with status
// ok; an empty-stack pop or a push past the limit sends 0 with an error status
// and clears the stack. Other characters produce no transaction.
// Characters are handled by a sequencer around the single read port of the
// stack memory; a divide makes eight passes through the shared subtractor,
// and an end marker also loads the output register. A zero divisor drops
// both operands and pushes nothing.
// The block takes a new character only when its sequencer is idle; a finished
// result waits in the output register, and further characters are still
// taken until another result is due while the first is stalled.
// stack_limit is written over the APB port at address 0 (reset 16).
// Reset (synchronous, active low) empties the stack and drops any pending
// output; stack contents need no clearing.

module rpn_digit_stack_calculator #(
    parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rpn_pkg::DATA_W-1:0]         i_token_char,
    input  logic                               i_is_end,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [rpn_pkg::DATA_W-1:0]  o_result_value,
    output logic [rpn_pkg::STATUS_W-1:0]       o_status,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rpn_pkg::ADDR_W-1:0]         paddr,
    input  logic [rpn_pkg::APB_W-1:0]          pwdata,
    output logic [rpn_pkg::APB_W-1:0]          prdata,
    output logic                               pready
);

    localparam int DW    = rpn_pkg::DATA_W;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CMP_W = (CNT_W > rpn_pkg::LIMIT_W) ? CNT_W : rpn_pkg::LIMIT_W;

    rpn_pkg::t_state r_state, n_state;
    rpn_pkg::t_op    r_op, n_op;

    logic [rpn_pkg::LIMIT_W-1:0]  r_limit, n_limit;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [DW-1:0]                r_a, n_a;
    logic [DW-1:0]                r_res, n_res;
    logic [rpn_pkg::STATUS_W-1:0] r_stat, n_stat;
    logic [DW-1:0]                r_dvd, n_dvd;
    logic [DW-1:0]                r_dvs, n_dvs;
    logic [DW-1:0]                r_rem, n_rem;
    logic                         r_neg, n_neg;
    logic [rpn_pkg::DIV_STEP_W-1:0] r_step, n_step;

    logic                         r_out_valid, n_out_valid;
    logic [DW-1:0]                r_out_value, n_out_value;
    logic [rpn_pkg::STATUS_W-1:0] r_out_status, n_out_status;

    // stack memory
    logic [DW-1:0] r_mem [STACK_DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [CNT_W-1:0] w_top;
    logic [AW-1:0]    w_rd_idx;
    logic [AW-1:0]    w_wr_idx;
    logic             w_mem_we;

    logic          w_in_fire;
    logic          w_cfg_wr;
    logic          w_can_push;
    logic [DW-1:0] w_b;
    logic [DW-1:0] w_abs_a;
    logic [DW-1:0] w_abs_b;
    logic [DW:0]   w_shift;
    logic          w_qbit;
    logic [DW-1:0] w_quot;

    assign o_in_ready     = (r_state == rpn_pkg::S_IDLE);
    assign w_in_fire      = i_in_valid && o_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

    // APB access: always ready, single register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite
                      && (paddr[rpn_pkg::ADDR_W-1:2] == rpn_pkg::REG_STACK_LIMIT);
    assign prdata   = (paddr[rpn_pkg::ADDR_W-1:2] == rpn_pkg::REG_STACK_LIMIT)
                      ? rpn_pkg::APB_W'(r_limit) : '0;

    always_comb begin
        n_limit = w_cfg_wr ? pwdata[rpn_pkg::LIMIT_W-1:0] : r_limit;
    end

    // Stack addressing: read the current top, write one above it
    assign w_top    = r_count - CNT_W'(1);
    assign w_rd_idx = w_top[AW-1:0];
    assign w_wr_idx = r_count[AW-1:0];
    assign w_can_push = (CMP_W'(r_count) < CMP_W'(r_limit))
                        && (CMP_W'(r_count) < CMP_W'(STACK_DEPTH));

    // Operand b arrives from the memory read register
    assign w_b     = r_rd_data;
    assign w_abs_a = r_a[DW-1] ? (~r_a + DW'(1)) : r_a;
    assign w_abs_b = w_b[DW-1] ? (~w_b + DW'(1)) : w_b;

    // Shared restoring divider step: one quotient bit per cycle
    assign w_shift = {r_rem, r_dvd[DW-1]};
    assign w_qbit  = (w_shift >= {1'b0, r_dvs});
    assign w_quot  = {r_dvd[DW-2:0], w_qbit};

    // Sequencer: next state and datapath
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_count      = r_count;
        n_a          = r_a;
        n_res        = r_res;
        n_stat       = r_stat;
        n_dvd        = r_dvd;
        n_dvs        = r_dvs;
        n_rem        = r_rem;
        n_neg        = r_neg;
        n_step       = r_step;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_mem_we     = 1'b0;

        // drop the output once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rpn_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    if (i_is_end) begin
                        if (r_count == '0) begin
                            n_res   = '0;
                            n_stat  = rpn_pkg::ST_EMPTY;
                            n_state = rpn_pkg::S_EMIT;
                        end else begin
                            n_state = rpn_pkg::S_POP_END;
                        end
                    end else begin
                        case (i_token_char) inside
                            [rpn_pkg::CH_ZERO:rpn_pkg::CH_NINE]: begin
                                n_res   = i_token_char - rpn_pkg::CH_ZERO;
                                n_state = rpn_pkg::S_PUSH;
                            end
                            rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS,
                            rpn_pkg::CH_STAR, rpn_pkg::CH_SLASH: begin
                                case (i_token_char)
                                    rpn_pkg::CH_PLUS:  n_op = rpn_pkg::OP_ADD;
                                    rpn_pkg::CH_MINUS: n_op = rpn_pkg::OP_SUB;
                                    rpn_pkg::CH_STAR:  n_op = rpn_pkg::OP_MUL;
                                    default:           n_op = rpn_pkg::OP_DIV;
                                endcase
                                if (r_count == '0) begin
                                    n_res   = '0;
                                    n_stat  = rpn_pkg::ST_EMPTY;
                                    n_state = rpn_pkg::S_EMIT;
                                end else begin
                                    n_state = rpn_pkg::S_POP_A;
                                end
                            end
                            default: begin
                                n_state = rpn_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end

            // read the top value, then clear the stack
            rpn_pkg::S_POP_END: begin
                n_count = '0;
                n_state = rpn_pkg::S_END_OUT;
            end

            rpn_pkg::S_END_OUT: begin
                n_res   = r_rd_data;
                n_stat  = rpn_pkg::ST_OK;
                n_state = rpn_pkg::S_EMIT;
            end

            // pop operand a
            rpn_pkg::S_POP_A: begin
                n_count = w_top;
                n_state = rpn_pkg::S_POP_B;
            end

            // hold a, pop operand b
            rpn_pkg::S_POP_B: begin
                n_a = r_rd_data;
                if (r_count == '0) begin
                    n_res   = '0;
                    n_stat  = rpn_pkg::ST_EMPTY;
                    n_state = rpn_pkg::S_EMIT;
                end else begin
                    n_count = w_top;
                    n_state = rpn_pkg::S_EXEC;
                end
            end

            // add, subtract and multiply directly, or load the divider; a zero divisor returns to idle
            rpn_pkg::S_EXEC: begin
                case (r_op)
                    rpn_pkg::OP_ADD: begin
                        n_res   = w_b + r_a;
                        n_state = rpn_pkg::S_PUSH;
                    end
                    rpn_pkg::OP_SUB: begin
                        n_res   = w_b - r_a;
                        n_state = rpn_pkg::S_PUSH;
                    end
                    rpn_pkg::OP_MUL: begin
                        n_res   = w_b * r_a;
                        n_state = rpn_pkg::S_PUSH;
                    end
                    default: begin
                        if (r_a == '0) begin
                            n_state = rpn_pkg::S_IDLE;
                        end else begin
                            n_dvd   = w_abs_b;
                            n_dvs   = w_abs_a;
                            n_rem   = '0;
                            n_neg   = w_b[DW-1] ^ r_a[DW-1];
                            n_step  = '0;
                            n_state = rpn_pkg::S_DIV;
                        end
                    end
                endcase
            end

            // advance the divider one bit
            rpn_pkg::S_DIV: begin
                n_rem  = w_qbit ? DW'(w_shift - {1'b0, r_dvs}) : w_shift[DW-1:0];
                n_dvd  = w_quot;
                n_step = r_step + rpn_pkg::DIV_STEP_W'(1);
                if (r_step == rpn_pkg::DIV_STEP_W'(DW - 1)) begin
                    n_res   = r_neg ? (~w_quot + DW'(1)) : w_quot;
                    n_state = rpn_pkg::S_PUSH;
                end
            end

            // push the result, or report overflow
            rpn_pkg::S_PUSH: begin
                if (w_can_push) begin
                    w_mem_we = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                    n_state  = rpn_pkg::S_IDLE;
                end else begin
                    n_count = '0;
                    n_res   = '0;
                    n_stat  = rpn_pkg::ST_OVERFLOW;
                    n_state = rpn_pkg::S_EMIT;
                end
            end

            // load the output register once it is free; errors also clear the stack
            rpn_pkg::S_EMIT: begin
                if (r_stat != rpn_pkg::ST_OK) begin
                    n_count = '0;
                end
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res;
                    n_out_status = r_stat;
                    n_state      = rpn_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rpn_pkg::S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= rpn_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_limit     <= n_limit;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_a          <= n_a;
        r_res        <= n_res;
        r_stat       <= n_stat;
        r_dvd        <= n_dvd;
        r_dvs        <= n_dvs;
        r_rem        <= n_rem;
        r_neg        <= n_neg;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // Stack memory: one write port, one registered read port at the top
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_idx] <= r_res;
        end
        r_rd_data <= r_mem[w_rd_idx];
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_push_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (CMP_W'(r_count) < CMP_W'(r_limit)) && (r_count < CNT_W'(STACK_DEPTH)))
        else $error("push past effective limit");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpn_pkg::S_DIV) |-> (r_dvs != '0))
        else $error("divider running with zero divisor");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpn_pkg::S_END_OUT) |-> (r_count == '0))
        else $error("stack not cleared after end marker");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpn_pkg::S_EMIT) && r_out_valid && !i_out_ready
        |=> (r_state == rpn_pkg::S_EMIT) && $stable(r_out_value))
        else $error("pending result overwritten");

endmodule

// File: bench/rpn_digit_stack_calculator_tb.sv
`timescale 1ns / 1ps

module rpn_digit_stack_calculator_tb;

    import rpn_pkg::*;

    localparam int STACK_DEPTH   = DEF_STACK_DEPTH;
    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_TOKENS = 1700;
    localparam int SETTLE_CYCLES = 30;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct packed {
        logic [DATA_W-1:0] ch;
        logic              fin;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } outcome_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [DATA_W-1:0]   i_token_char = '0;
    logic                i_is_end     = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic signed [DATA_W-1:0] o_result_value;
    logic [STATUS_W-1:0] o_status;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [APB_W-1:0]  pwdata  = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    // Pending characters and the results they are due to produce
    token_t   char_stream[$];
    outcome_t results_due[$];

    // Calculator state mirrored by the bench
    logic [DATA_W-1:0]  operand_stack[STACK_DEPTH];
    int                 operand_count = 0;
    logic [LIMIT_W-1:0] limit_cfg     = LIMIT_RESET;

    int tokens_made = 0;
    int mismatches  = 0;
    int feed_wait   = 0;
    int drain_wait  = 0;
    bit feed_calm   = 1'b0;
    bit drain_calm  = 1'b0;

    rpn_digit_stack_calculator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_token_char   (i_token_char),
        .i_is_end       (i_is_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Entries actually available: the register capped at the physical depth
    function automatic int usable_depth();
        return (int'(limit_cfg) < STACK_DEPTH) ? int'(limit_cfg) : STACK_DEPTH;
    endfunction

    function automatic void abort_expression(input logic [STATUS_W-1:0] code);
        outcome_t o;
        operand_count = 0;
        o.value  = '0;
        o.status = code;
        results_due.push_back(o);
    endfunction

    // Work out the effect of one accepted character on the mirrored stack
    function automatic void evaluate_token(input logic [DATA_W-1:0] ch, input logic fin);
        outcome_t o;
        logic [DATA_W-1:0] a, b, r;
        int sa, sb;
        if (fin) begin
            if (operand_count == 0) begin
                abort_expression(ST_EMPTY);
            end else begin
                operand_count--;
                o.value  = operand_stack[operand_count];
                o.status = ST_OK;
                results_due.push_back(o);
                operand_count = 0;
            end
            return;
        end
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (operand_count >= usable_depth()) begin
                abort_expression(ST_OVERFLOW);
            end else begin
                operand_stack[operand_count] = ch - CH_ZERO;
                operand_count++;
            end
            return;
        end
        if (ch != CH_PLUS && ch != CH_MINUS && ch != CH_STAR && ch != CH_SLASH)
            return;
        if (operand_count == 0) begin
            abort_expression(ST_EMPTY);
            return;
        end
        operand_count--;
        a = operand_stack[operand_count];
        if (operand_count == 0) begin
            abort_expression(ST_EMPTY);
            return;
        end
        operand_count--;
        b = operand_stack[operand_count];
        case (ch)
            CH_PLUS:  r = b + a;
            CH_MINUS: r = b - a;
            CH_STAR:  r = b * a;
            default: begin
                // a zero divisor drops both operands silently
                if (a == '0)
                    return;
                sb = $signed(b);
                sa = $signed(a);
                r  = DATA_W'(sb / sa);
            end
        endcase
        if (operand_count >= usable_depth()) begin
            abort_expression(ST_OVERFLOW);
        end else begin
            operand_stack[operand_count] = r;
            operand_count++;
        end
    endfunction

    function automatic void flag_mismatch(input string detail);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, detail);
    endfunction

    function automatic void add_token(input logic [DATA_W-1:0] ch, input logic fin);
        token_t t;
        t.ch  = ch;
        t.fin = fin;
        char_stream.push_back(t);
        tokens_made++;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operator();
        case (t_op'($urandom_range(0, 3)))
            OP_ADD:  return CH_PLUS;
            OP_SUB:  return CH_MINUS;
            OP_MUL:  return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_digit();
        return CH_ZERO + DATA_W'($urandom_range(0, 9));
    endfunction

    // Queue a well-formed expression whose depth stays within a chosen peak;
    // now and then the peak sits one above the usable depth to provoke an overflow
    function automatic void queue_expression();
        int cap, peak, n, pushed, d;
        bit can_push, can_op;
        token_t stray;
        cap  = usable_depth();
        peak = (cap == 0) ? 1 : $urandom_range(1, cap);
        if ($urandom_range(0, 7) == 0)
            peak = cap + 1;
        n      = $urandom_range(1, 12);
        pushed = 0;
        d      = 0;
        forever begin
            can_push = pushed < n && d < peak;
            can_op   = d >= 2;
            if (!can_push && !can_op)
                break;
            if (can_push && (!can_op || $urandom_range(0, 1) == 1)) begin
                add_token(pick_digit(), 1'b0);
                pushed++;
                d++;
            end else begin
                add_token(pick_operator(), 1'b0);
                d--;
            end
            // sprinkle characters that the block simply skips
            if ($urandom_range(0, 19) == 0) begin
                do
                    stray.ch = DATA_W'($urandom_range(0, 255));
                while ((stray.ch >= CH_ZERO && stray.ch <= CH_NINE) || stray.ch == CH_PLUS
                       || stray.ch == CH_MINUS || stray.ch == CH_STAR
                       || stray.ch == CH_SLASH);
                stray.fin = 1'b0;
                char_stream.push_back(stray);
            end
        end
        add_token(DATA_W'($urandom_range(0, 255)), 1'b1);
    endfunction

    // Queue a short run of arbitrary tokens and end markers
    function automatic void queue_noise();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
                0:       add_token(DATA_W'($urandom_range(0, 255)), 1'b0);
                1:       add_token(pick_digit(), 1'b0);
                2:       add_token(pick_operator(), 1'b0);
                default: add_token(DATA_W'($urandom_range(0, 255)), 1'b1);
            endcase
        end
    endfunction

    // Wait until every character is taken, every result delivered and the
    // sequencer has had time to finish silent work
    task automatic drain_phase();
        @(negedge i_clk);
        while (char_stream.size() != 0 || i_in_valid)
            @(negedge i_clk);
        while (results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stack_limit(input logic [LIMIT_W-1:0] lim);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_STACK_LIMIT, 2'b00};
        pwdata  <= APB_W'(lim);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_cfg = lim;
    endtask

    // Drive characters from the queue, predicting each on acceptance
    always @(posedge i_clk) begin : feed_driver
        token_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                evaluate_token(i_token_char, i_is_end);
            if (!i_in_valid || o_in_ready) begin
                if (feed_wait > 0) begin
                    feed_wait--;
                    i_in_valid <= 1'b0;
                end else if (char_stream.size() > 0) begin
                    nxt = char_stream.pop_front();
                    i_token_char <= nxt.ch;
                    i_is_end     <= nxt.fin;
                    i_in_valid   <= 1'b1;
                    if ($urandom_range(0, 23) == 0)
                        feed_calm = !feed_calm;
                    feed_wait = feed_calm ? 0 : $urandom_range(0, 17);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side for a random number of cycles after each transaction
    always @(posedge i_clk) begin : drain_driver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if ($urandom_range(0, 23) == 0)
                    drain_calm = !drain_calm;
                drain_wait = drain_calm ? 0 : $urandom_range(0, 17);
            end
            if (drain_wait > 0) begin
                drain_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        outcome_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: value %0d, status %0d",
                                        o_result_value, o_status));
            end else begin
                want = results_due.pop_front();
                if (o_result_value !== want.value)
                    flag_mismatch($sformatf("result_value: expected %0d, got %0d",
                                            $signed(want.value), o_result_value));
                if (o_status !== want.status)
                    flag_mismatch($sformatf("status: expected %0d, got %0d",
                                            want.status, o_status));
            end
        end
    end

    initial begin : stimulus
        int phase, target;
        logic [LIMIT_W-1:0] lim;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: errors on an empty stack
        add_token(8'hFF, 1'b1);
        add_token(CH_PLUS, 1'b0);
        add_token(CH_ZERO + 8'd7, 1'b0);
        add_token(CH_STAR, 1'b0);
        // divide by zero drops both operands
        add_token(CH_ZERO + 8'd9, 1'b0);
        add_token(CH_ZERO, 1'b0);
        add_token(CH_SLASH, 1'b0);
        // product wraps past 127
        add_token(CH_NINE, 1'b0);
        add_token(CH_NINE, 1'b0);
        add_token(CH_STAR, 1'b0);
        add_token(CH_NINE, 1'b0);
        add_token(CH_STAR, 1'b0);
        add_token(8'h00, 1'b1);
        // ignored characters
        add_token(8'h00, 1'b0);
        add_token(8'hFF, 1'b0);
        // minus 128 divided by minus 1 wraps back to minus 128
        add_token(CH_ZERO + 8'd8, 1'b0);
        add_token(CH_ZERO + 8'd4, 1'b0);
        add_token(CH_ZERO + 8'd4, 1'b0);
        add_token(CH_STAR, 1'b0);
        add_token(CH_STAR, 1'b0);
        add_token(CH_ZERO, 1'b0);
        add_token(CH_ZERO + 8'd1, 1'b0);
        add_token(CH_MINUS, 1'b0);
        add_token(CH_SLASH, 1'b0);
        add_token(8'hFF, 1'b1);
        // leave three entries for the lowered limit that follows
        add_token(CH_ZERO + 8'd1, 1'b0);
        add_token(CH_ZERO + 8'd2, 1'b0);
        add_token(CH_ZERO + 8'd3, 1'b0);
        drain_phase();

        // Random phases, each under its own stack limit
        tokens_made = 0;
        phase       = 0;
        while (tokens_made < RANDOM_TOKENS) begin
            case (phase)
                0:       lim = 5'd1;
                1:       lim = 5'd0;
                2:       lim = 5'd31;
                3:       lim = 5'd2;
                4:       lim = 5'd16;
                default: lim = LIMIT_W'($urandom_range(0, 31));
            endcase
            write_stack_limit(lim);
            // a push onto entries now above the limit must overflow
            if (phase == 0)
                add_token(CH_ZERO + 8'd4, 1'b0);
            target = tokens_made + $urandom_range(60, 200);
            while (tokens_made < target) begin
                if ($urandom_range(0, 6) == 0)
                    queue_noise();
                else
                    queue_expression();
            end
            // sometimes end the phase mid-expression
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) add_token(pick_digit(), 1'b0);
            drain_phase();
            phase++;
        end

        if (results_due.size() != 0)
            flag_mismatch($sformatf("%0d results never delivered", results_due.size()));
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
hdl/rpn_pkg.sv
hdl/rpn_digit_stack_calculator.sv
bench/rpn_digit_stack_calculator_tb.sv
